// ----- rtl/core/hash_list_line_parser_macros.svh -----
// Assertion macros for the checksum-list line parser.
// Relies on clk and rst_n being in scope where a macro is used.
`ifndef HASH_LIST_LINE_PARSER_MACROS_SVH
`define HASH_LIST_LINE_PARSER_MACROS_SVH

`ifndef SYNTH

`define HLL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`define HLL_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`else

`define HLL_ASSERT(label, prop, msg)

`define HLL_ASSERT_NEVER(label, expr, msg)

`endif

`endif

// ----- rtl/core/hll_pkg.sv -----
// Shared types and constants for the checksum-list line parser.
// No dependencies.
`timescale 1ns / 1ps

package hll_pkg;

    localparam int DIGEST_BYTES_DEF = 32;
    localparam int DIGEST_INDEX_W   = 5;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef enum logic [3:0] {
        PH_DIGEST = 4'b0001,
        PH_SPACES = 4'b0010,
        PH_NAME   = 4'b0100,
        PH_REST   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_DIGEST = 3'd0,
        KIND_NAME   = 3'd1,
        KIND_OK     = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_END    = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t     phase;
        logic       second_nibble;
        logic [3:0] high_nibble;
    } parse_state_t;

    typedef struct packed {
        logic                      emit;
        kind_t                     kind;
        logic [7:0]                value;
        logic [DIGEST_INDEX_W-1:0] digest_index;
    } result_t;

endpackage

// ----- rtl/core/hll_decoder.sv -----
// Per-word parse step: current state and one byte in, next state and result out.
// Depends on hll_pkg.
`timescale 1ns / 1ps

module hll_decoder
    import hll_pkg::*;
#(
    parameter int  DIGEST_BYTES = DIGEST_BYTES_DEF,
    localparam int POS_W        = $clog2(DIGEST_BYTES)
)
(
    input  logic [7:0]       data_byte,
    input  logic             end_of_input,
    input  parse_state_t     state_cur,
    input  logic [POS_W-1:0] pos_cur,
    output parse_state_t     state_nxt,
    output logic [POS_W-1:0] pos_nxt,
    output result_t          result
);

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } hex_t;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGEST_BYTES - 1);

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t       h;
        logic [7:0] d;
        h = '0;
        d = '0;
        if (c inside {[8'h30:8'h39]})
        begin
            d = c - 8'h30;
            h = '{ok: 1'b1, nib: d[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            d = c - 8'h57;
            h = '{ok: 1'b1, nib: d[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            d = c - 8'h37;
            h = '{ok: 1'b1, nib: d[3:0]};
        end
        return h;
    endfunction

    hex_t                            hexd;
    logic [7:0]                      name_char;
    logic [DIGEST_INDEX_W+POS_W-1:0] pos_ext;

    assign hexd      = hex_decode(data_byte);
    assign name_char = (data_byte == CH_SLASH) ? CH_BACKSLASH : data_byte;
    assign pos_ext   = {{DIGEST_INDEX_W{1'b0}}, pos_cur};

    localparam parse_state_t LINE_START = '{
        phase: PH_DIGEST, second_nibble: 1'b0, high_nibble: 4'h0};

    always_comb
    begin
        state_nxt = state_cur;
        pos_nxt   = pos_cur;
        result    = '{emit: 1'b0, kind: KIND_DIGEST, value: 8'h00,
                      digest_index: '0};

        if (end_of_input)
        begin
            state_nxt   = LINE_START;
            pos_nxt     = '0;
            result.emit = 1'b1;
            result.kind = KIND_END;
        end
        else
        begin
            case (state_cur.phase)
                PH_DIGEST:
                begin
                    if (!hexd.ok)
                    begin
                        state_nxt   = LINE_START;
                        pos_nxt     = '0;
                        result.emit = 1'b1;
                        result.kind = KIND_ERROR;
                    end
                    else if (!state_cur.second_nibble)
                    begin
                        state_nxt.high_nibble   = hexd.nib;
                        state_nxt.second_nibble = 1'b1;
                    end
                    else
                    begin
                        state_nxt.second_nibble = 1'b0;
                        if (pos_cur == POS_LAST)
                        begin
                            pos_nxt         = '0;
                            state_nxt.phase = PH_SPACES;
                        end
                        else
                        begin
                            pos_nxt = pos_cur + POS_W'(1);
                        end
                        result.emit         = 1'b1;
                        result.kind         = KIND_DIGEST;
                        result.value        = {state_cur.high_nibble, hexd.nib};
                        result.digest_index = pos_ext[DIGEST_INDEX_W-1:0];
                    end
                end
                PH_SPACES:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        state_nxt   = LINE_START;
                        pos_nxt     = '0;
                        result.emit = 1'b1;
                        result.kind = KIND_ERROR;
                    end
                    else if (data_byte != CH_SPACE)
                    begin
                        state_nxt.phase = PH_NAME;
                        result.emit     = 1'b1;
                        result.kind     = KIND_NAME;
                        result.value    = name_char;
                    end
                end
                PH_NAME:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        state_nxt   = LINE_START;
                        pos_nxt     = '0;
                        result.emit = 1'b1;
                        result.kind = KIND_OK;
                    end
                    else if (data_byte == CH_SPACE)
                    begin
                        state_nxt.phase = PH_REST;
                    end
                    else
                    begin
                        result.emit  = 1'b1;
                        result.kind  = KIND_NAME;
                        result.value = name_char;
                    end
                end
                PH_REST:
                begin
                    if (data_byte == CH_NEWLINE)
                    begin
                        state_nxt   = LINE_START;
                        pos_nxt     = '0;
                        result.emit = 1'b1;
                        result.kind = KIND_OK;
                    end
                end
                default:
                begin
                    state_nxt = LINE_START;
                    pos_nxt   = '0;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/hash_list_line_parser.sv -----
// Checksum-list line parser: one byte per word in, at most one result per word out.
// Each byte is held in the input register and its result in the output register; the
// output register is loaded only while it is empty or its result is being taken.
// Throughput: one byte per cycle; a byte waits in the input register only while the
// output register holds a result not yet taken.
// Reset (rst_n low, asynchronous): both registers empty, parser at the start of a line.
// Depends on hll_pkg, hll_decoder and hash_list_line_parser_macros.svh.
`timescale 1ns / 1ps
`include "hash_list_line_parser_macros.svh"

module hash_list_line_parser
    import hll_pkg::*;
#(
    parameter int  DIGEST_BYTES = DIGEST_BYTES_DEF,
    localparam int POS_W        = $clog2(DIGEST_BYTES)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                data_byte,
    input  logic                      end_of_input,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [2:0]                kind,
    output logic [7:0]                value,
    output logic [DIGEST_INDEX_W-1:0] digest_index
);

    logic                      in_valid_reg, in_valid_next;
    logic [7:0]                data_reg;
    logic                      eof_reg;

    parse_state_t              state_reg, state_next;
    logic [POS_W-1:0]          pos_reg, pos_next;

    logic                      out_valid_reg, out_valid_next;
    kind_t                     kind_reg;
    logic [7:0]                value_reg;
    logic [DIGEST_INDEX_W-1:0] index_reg;

    result_t                   result;
    logic                      advance;
    logic                      in_take;

    hll_decoder #(
        .DIGEST_BYTES (DIGEST_BYTES)
    ) u_decoder (
        .data_byte    (data_reg),
        .end_of_input (eof_reg),
        .state_cur    (state_reg),
        .pos_cur      (pos_reg),
        .state_nxt    (state_next),
        .pos_nxt      (pos_next),
        .result       (result)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign in_take        = in_valid && in_ready;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = (advance && result.emit) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: PH_DIGEST, second_nibble: 1'b0, high_nibble: 4'h0};
            pos_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            data_reg <= data_byte;
            eof_reg  <= end_of_input;
        end
        if (advance && result.emit)
        begin
            kind_reg  <= result.kind;
            value_reg <= result.value;
            index_reg <= result.digest_index;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign value        = value_reg;
    assign digest_index = index_reg;

    // held word must not be dropped while the result side stalls
    `HLL_ASSERT(a_in_held, (in_valid_reg && !advance |=> in_valid_reg), "input word lost")

    `HLL_ASSERT(a_eof_restart, (advance && eof_reg |=> state_reg.phase == PH_DIGEST && pos_reg == '0 && !state_reg.second_nibble), "end of input did not restart the line")

    `HLL_ASSERT_NEVER(a_nibble_phase, (state_reg.second_nibble && state_reg.phase != PH_DIGEST), "half digest byte outside digest phase")

    `HLL_ASSERT(a_index_zero, (out_valid_reg && kind_reg != KIND_DIGEST |-> index_reg == '0), "digest index set on non-digest result")

    `HLL_ASSERT(a_value_zero, (out_valid_reg && (kind_reg == KIND_OK || kind_reg == KIND_ERROR || kind_reg == KIND_END) |-> value_reg == 8'h00), "value set on status result")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for hash_list_line_parser: checksum-list bytes in, results out.
// Predicts each result from its own line parser model and checks it; needs hll_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import hll_pkg::*;

    localparam int DIGEST_LEN  = DIGEST_BYTES_DEF;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic [4:0] digest_index;
    } outcome_t;

    class line_result_book;
        phase_t     stage;
        bit         second_digit;
        int         byte_at;
        logic [3:0] upper;
        outcome_t   due_results[$];
        int         failures;

        function new();
            restart();
            failures = 0;
        endfunction

        function void restart();
            stage        = PH_DIGEST;
            second_digit = 0;
            byte_at      = 0;
            upper        = '0;
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return int'(c) - int'("0");
            if (c >= "a" && c <= "f")
                return int'(c) - int'("a") + 10;
            if (c >= "A" && c <= "F")
                return int'(c) - int'("A") + 10;
            return -1;
        endfunction

        function void expect_result(kind_t k, logic [7:0] v, logic [4:0] i);
            outcome_t o;
            o.kind         = k;
            o.value        = v;
            o.digest_index = i;
            due_results.push_back(o);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // one accepted input word
        function void take_word(logic [7:0] b, logic eoi);
            int nib;
            if (eoi) begin
                restart();
                expect_result(KIND_END, 8'h00, 5'd0);
                return;
            end
            case (stage)
                PH_DIGEST:
                begin
                    nib = hex_digit(b);
                    if (nib < 0) begin
                        restart();
                        expect_result(KIND_ERROR, 8'h00, 5'd0);
                    end
                    else if (!second_digit) begin
                        upper        = nib[3:0];
                        second_digit = 1;
                    end
                    else begin
                        expect_result(KIND_DIGEST, {upper, nib[3:0]}, byte_at[4:0]);
                        second_digit = 0;
                        if (byte_at + 1 >= DIGEST_LEN) begin
                            byte_at = 0;
                            stage   = PH_SPACES;
                        end
                        else
                            byte_at++;
                    end
                end
                PH_SPACES:
                begin
                    if (b == CH_NEWLINE) begin
                        restart();
                        expect_result(KIND_ERROR, 8'h00, 5'd0);
                    end
                    else if (b != CH_SPACE) begin
                        stage = PH_NAME;
                        expect_result(KIND_NAME, (b == CH_SLASH) ? CH_BACKSLASH : b, 5'd0);
                    end
                end
                PH_NAME:
                begin
                    if (b == CH_NEWLINE) begin
                        restart();
                        expect_result(KIND_OK, 8'h00, 5'd0);
                    end
                    else if (b == CH_SPACE)
                        stage = PH_REST;
                    else
                        expect_result(KIND_NAME, (b == CH_SLASH) ? CH_BACKSLASH : b, 5'd0);
                end
                default:
                begin
                    if (b == CH_NEWLINE) begin
                        restart();
                        expect_result(KIND_OK, 8'h00, 5'd0);
                    end
                end
            endcase
        endfunction

        function void check_result(logic [2:0] k, logic [7:0] v, logic [4:0] i);
            outcome_t want;
            if (due_results.size() == 0) begin
                flag($sformatf("unexpected result: kind %0d value %02h index %0d", k, v, i));
                return;
            end
            want = due_results.pop_front();
            if (k !== want.kind || v !== want.value || i !== want.digest_index)
                flag($sformatf("mismatch: expected kind %0d value %02h index %0d, got kind %0d value %02h index %0d",
                    want.kind, want.value, want.digest_index, k, v, i));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       end_of_input;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] kind;
    logic [7:0] value;
    logic [4:0] digest_index;

    line_result_book book;
    int    send_idle_pct;
    int    recv_stall_pct;
    int    words_sent;
    int    quiet_cycles;
    string hex_chars = "0123456789abcdefABCDEF";

    hash_list_line_parser #(
        .DIGEST_BYTES (DIGEST_LEN)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value        (value),
        .digest_index (digest_index)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            book.check_result(kind, value, digest_index);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // entered and left at a falling edge
    task send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        book.take_word(b, eoi);
        words_sent++;
        @(negedge clk);
    endtask

    task send_digest(input int digits);
        repeat (digits)
            send_word(hex_chars[$urandom_range(0, 21)], 1'b0);
    endtask

    task send_spaces(input int n);
        repeat (n)
            send_word(CH_SPACE, 1'b0);
    endtask

    task send_name(input int n);
        logic [7:0] b;
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                b = CH_SLASH;
            else begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_SPACE || b == CH_NEWLINE);
            end
            send_word(b, 1'b0);
        end
    endtask

    // space, then trailing text that the parser skips
    task send_tail(input int n);
        logic [7:0] b;
        send_word(CH_SPACE, 1'b0);
        repeat (n) begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_NEWLINE);
            send_word(b, 1'b0);
        end
    endtask

    task send_bad_digit();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (book.hex_digit(b) >= 0);
        send_word(b, 1'b0);
    endtask

    task run_directed();
        send_word(8'h00, 1'b1);
        send_word("G", 1'b0);
        send_word(CH_NEWLINE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word("0", 1'b0);
        send_word("0", 1'b0);
        send_word("F", 1'b0);
        send_word("f", 1'b0);
        send_word("a", 1'b0);
        send_word("B", 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word("9", 1'b0);
        send_word(8'hFF, 1'b1);
        send_word("9", 1'b0);
        send_word("c", 1'b0);
        send_word(CH_NEWLINE, 1'b0);
        // name straight after digest, odd bytes, trailing text
        send_digest(2 * DIGEST_LEN);
        send_word(CH_SLASH, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h0D, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_SPACE, 1'b0);
        send_word(CH_NEWLINE, 1'b0);
        // newline before the name
        send_digest(2 * DIGEST_LEN);
        send_spaces(2);
        send_word(CH_NEWLINE, 1'b0);
        // file end inside the name
        send_digest(2 * DIGEST_LEN);
        send_spaces(1);
        send_word("x", 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    task run_random(input int target);
        int first;
        int pick;
        int cut;
        first = words_sent;
        while (words_sent - first < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                send_digest(2 * DIGEST_LEN);
                send_spaces($urandom_range(0, 3));
                send_name($urandom_range(1, 12));
                if ($urandom_range(0, 1))
                    send_tail($urandom_range(0, 6));
                send_word(CH_NEWLINE, 1'b0);
            end
            else if (pick < 68) begin
                send_digest(2 * DIGEST_LEN);
                send_spaces($urandom_range(0, 3));
                send_word(CH_NEWLINE, 1'b0);
            end
            else if (pick < 78) begin
                send_digest($urandom_range(0, 2 * DIGEST_LEN - 1));
                if ($urandom_range(0, 1))
                    send_word(CH_NEWLINE, 1'b0);
                else
                    send_bad_digit();
            end
            else if (pick < 88) begin
                cut = $urandom_range(0, 3);
                send_digest(cut == 0 ? $urandom_range(0, 2 * DIGEST_LEN - 1) : 2 * DIGEST_LEN);
                if (cut > 0)
                    send_spaces($urandom_range(1, 3));
                if (cut > 1)
                    send_name($urandom_range(1, 5));
                if (cut > 2)
                    send_tail($urandom_range(0, 4));
                send_word(8'($urandom_range(0, 255)), 1'b1);
            end
            else begin
                repeat ($urandom_range(1, 6))
                    send_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        end_of_input   = 1'b0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        quiet_cycles   = 0;
        book           = new();

        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        run_random(210);
        send_idle_pct = 53;
        run_random(210);
        send_idle_pct  = 0;
        recv_stall_pct = 53;
        run_random(210);
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        run_random(210);
        in_valid <= 1'b0;

        while (book.due_results.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (book.failures == 0 && book.due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
